### design/assert_macros.svh
// Assertion macros used by the modulator top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, off while reset is held.
`define ZCBM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// Clocked check that stays on through reset.
`define ZCBM_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define ZCBM_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define ZCBM_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

### design/zcbm_pkg.sv
// Constants and field widths of the zero-crossing burst modulator.
`timescale 1ns / 1ps
package zcbm_pkg;

  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 5;
  localparam int HALF_W  = 14;

  localparam int LEVEL_STEPS_DEF = 20;
  localparam int CAL_EVENTS_DEF  = 32;

  // Half period limits in us: 45 Hz .. 66 Hz line
  localparam logic [HALF_W-1:0] DEFAULT_HALF_US = 14'd8333;
  localparam int                MIN_HALF_US     = 7576;
  localparam int                MAX_HALF_US     = 11111;

endpackage

### design/zero_cross_burst_modulator_top.sv
// Zero-crossing burst-fire modulator: Bresenham gates, window trigger, line measurement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_     | to block  | in_valid / in_stall  | event_time_us, heater/fan level, start
//  out_    | from block| out_valid / out_stall| gates, trigger, cal done, default, period
//
// One item per cycle sustained while out_stall does not hold the result register; an accepted
// item is held in the input register, then goes through one pass of accumulate/compare/multiply
// logic into the result register, from which its result is taken.
// The divide of the measured span is a constant-reciprocal multiply in that same pass.
// Reset (synchronous, rst_n low) clears valids, accumulators, counters and sets the
// half period to 8333 us. out_stall holds the result register; the input register
// then fills and in_stall rises in the same cycle.
module zero_cross_burst_modulator_top #(
  parameter int LEVEL_STEPS = zcbm_pkg::LEVEL_STEPS_DEF,
  parameter int CAL_EVENTS  = zcbm_pkg::CAL_EVENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [zcbm_pkg::TIME_W-1:0]  in_event_time_us,
  input  logic [zcbm_pkg::LEVEL_W-1:0] in_heater_level,
  input  logic [zcbm_pkg::LEVEL_W-1:0] in_fan_level,
  input  logic                         in_start_calibration,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_heater_gate,
  output logic                         out_fan_gate,
  output logic                         out_sample_trigger,
  output logic                         out_calibration_done,
  output logic                         out_used_default,
  output logic [zcbm_pkg::HALF_W-1:0]  out_half_period_us
);
  import zcbm_pkg::*;

  localparam int ACC_W    = $clog2(LEVEL_STEPS + 32);
  localparam int WIN_W    = $clog2(LEVEL_STEPS);
  localparam int SMP_W    = $clog2(CAL_EVENTS);
  localparam int DIV      = CAL_EVENTS - 1;
  localparam int SPAN_LO  = MIN_HALF_US * DIV;
  localparam int SPAN_HI  = (MAX_HALF_US + 1) * DIV;   // exclusive
  localparam int QX_W     = $clog2(SPAN_HI);
  localparam int SHIFT    = QX_W + $clog2(DIV);
  localparam int RECIP_W  = QX_W + 2;
  localparam int PROD_W   = QX_W + RECIP_W;
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

  // input register
  logic               s1_valid_r;
  logic [TIME_W-1:0]  s1_time_r;
  logic [LEVEL_W-1:0] s1_heat_r;
  logic [LEVEL_W-1:0] s1_fan_r;
  logic               s1_start_r;

  // block state
  logic [ACC_W-1:0]   heat_acc_r, heat_acc_nxt;
  logic [ACC_W-1:0]   fan_acc_r, fan_acc_nxt;
  logic [WIN_W-1:0]   win_r, win_nxt;
  logic               meas_r, meas_nxt;
  logic [SMP_W-1:0]   smp_r, smp_nxt;
  logic [TIME_W-1:0]  first_r, first_nxt;
  logic [HALF_W-1:0]  half_r, half_nxt;

  // result register
  logic               out_valid_r;
  logic               heat_gate_r, fan_gate_r, trig_r, done_r, dflt_r;
  logic [HALF_W-1:0]  out_half_r;

  logic               advance, s1_move;
  logic [ACC_W-1:0]   heat_lvl, fan_lvl, heat_sum, fan_sum;
  logic               heat_gate, fan_gate, win_wrap;
  logic               done, dflt;
  logic [TIME_W-1:0]  span;
  logic               span_ok;
  logic [PROD_W-1:0]  quot_prod;
  logic [HALF_W-1:0]  quotient;

  assign advance  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // Bresenham gates, levels saturated to LEVEL_STEPS
  always_comb begin
    heat_lvl = (ACC_W'(s1_heat_r) > ACC_W'(LEVEL_STEPS)) ? ACC_W'(LEVEL_STEPS)
                                                          : ACC_W'(s1_heat_r);
    fan_lvl  = (ACC_W'(s1_fan_r) > ACC_W'(LEVEL_STEPS)) ? ACC_W'(LEVEL_STEPS)
                                                         : ACC_W'(s1_fan_r);
    heat_sum = heat_acc_r + heat_lvl;
    fan_sum  = fan_acc_r + fan_lvl;
    heat_gate = heat_sum >= ACC_W'(LEVEL_STEPS);
    fan_gate  = fan_sum >= ACC_W'(LEVEL_STEPS);
    heat_acc_nxt = heat_gate ? heat_sum - ACC_W'(LEVEL_STEPS) : heat_sum;
    fan_acc_nxt  = fan_gate ? fan_sum - ACC_W'(LEVEL_STEPS) : fan_sum;
    win_wrap = win_r == WIN_W'(LEVEL_STEPS - 1);
    win_nxt  = win_wrap ? '0 : win_r + WIN_W'(1);
  end

  // Span / (CAL_EVENTS-1): range test on the span itself, then reciprocal
  // multiply, exact for every span below the upper limit.
  always_comb begin
    span      = s1_time_r - first_r;
    span_ok   = (span >= 32'(SPAN_LO)) && (span < 32'(SPAN_HI));
    quot_prod = PROD_W'(span[QX_W-1:0]) * PROD_W'(RECIP);
    quotient  = quot_prod[SHIFT +: HALF_W];
  end

  always_comb begin
    meas_nxt  = meas_r;
    smp_nxt   = smp_r;
    first_nxt = first_r;
    half_nxt  = half_r;
    done      = 1'b0;
    dflt      = 1'b0;
    if (s1_start_r) begin
      meas_nxt  = 1'b1;
      smp_nxt   = SMP_W'(1);
      first_nxt = s1_time_r;
    end else if (meas_r) begin
      smp_nxt = smp_r + SMP_W'(1);
      if (smp_r == SMP_W'(CAL_EVENTS - 1)) begin
        meas_nxt = 1'b0;
        done     = 1'b1;
        if (span_ok) begin
          half_nxt = quotient;
        end else begin
          half_nxt = DEFAULT_HALF_US;
          dflt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_time_r  <= in_event_time_us;
      s1_heat_r  <= in_heater_level;
      s1_fan_r   <= in_fan_level;
      s1_start_r <= in_start_calibration;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_acc_r <= '0;
      fan_acc_r  <= '0;
      win_r      <= '0;
      meas_r     <= 1'b0;
      smp_r      <= '0;
      first_r    <= '0;
      half_r     <= DEFAULT_HALF_US;
    end else if (s1_move) begin
      heat_acc_r <= heat_acc_nxt;
      fan_acc_r  <= fan_acc_nxt;
      win_r      <= win_nxt;
      meas_r     <= meas_nxt;
      smp_r      <= smp_nxt;
      first_r    <= first_nxt;
      half_r     <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      heat_gate_r <= heat_gate;
      fan_gate_r  <= fan_gate;
      trig_r      <= win_wrap;
      done_r      <= done;
      dflt_r      <= dflt;
      out_half_r  <= half_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_heater_gate      = heat_gate_r;
  assign out_fan_gate         = fan_gate_r;
  assign out_sample_trigger   = trig_r;
  assign out_calibration_done = done_r;
  assign out_used_default     = dflt_r;
  assign out_half_period_us   = out_half_r;

  `ZCBM_ASSERT(a_acc_bound, clk, rst_n,
    (heat_acc_r < ACC_W'(LEVEL_STEPS)) && (fan_acc_r < ACC_W'(LEVEL_STEPS)),
    "accumulator reached LEVEL_STEPS")
  `ZCBM_ASSERT(a_half_range, clk, rst_n,
    (half_r >= HALF_W'(MIN_HALF_US)) && (half_r <= HALF_W'(MAX_HALF_US)),
    "half period out of line range")
  `ZCBM_ASSERT(a_meas_count, clk, rst_n,
    meas_r |-> ((smp_r != '0) && (smp_r <= SMP_W'(CAL_EVENTS - 1))),
    "sample count invalid while measuring")
  `ZCBM_ASSERT_ALWAYS(a_dflt_done, clk,
    (rst_n && out_valid_r && dflt_r) |-> done_r,
    "default flagged without calibration done")

endmodule
